// File: hdl/stepped_freq_governor_with_floor_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stepped frequency governor
// Concurrent checks on clock, quietened while reset is high. They expand to
// nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef STEPPED_FREQ_GOVERNOR_WITH_FLOOR_UNIT_MACROS_SVH
`define STEPPED_FREQ_GOVERNOR_WITH_FLOOR_UNIT_MACROS_SVH

`ifndef SYNTH

`define SFG_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("governor check failed");

`define SFG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("governor check failed");

`else

`define SFG_ASSERT_SAME(label, ante, cons)

`define SFG_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: hdl/sfg_pkg.sv
// ----------------------------------------------------------------------------
// Stepped frequency governor package
// Beat types, register indexes and the constants of the division by one
// hundred that turns percentages of the maximum frequency into kHz.
// ----------------------------------------------------------------------------
package sfg_pkg;

   localparam int FREQ_BITS = 24;
   localparam int PCT_BITS = 7;
   localparam int ADDR_BITS = 5;
   localparam int DATA_BITS = 32;

   localparam int QUOT_BITS = FREQ_BITS - 6;
   localparam int RECIP_SHIFT = FREQ_BITS + 7;
   localparam int RECIP_BITS = FREQ_BITS + 1;
   localparam logic [63:0] RECIP_WIDE = (64'd1 << RECIP_SHIFT) / 64'd100;
   localparam logic [RECIP_BITS-1:0] FREQ_RECIP = RECIP_WIDE[RECIP_BITS-1:0];

   localparam int SMALL_BITS = 2 * PCT_BITS;
   localparam int PCT_RECIP_SHIFT = 20;
   localparam logic [SMALL_BITS-1:0] PCT_RECIP = 14'd10486;

   localparam int REM_BITS = 8;
   localparam logic [REM_BITS-1:0] HUNDRED = 8'd100;

   localparam int SCALE_LATENCY = 5;
   localparam int SETTLE_BITS = $clog2(SCALE_LATENCY);
   localparam logic [SETTLE_BITS-1:0] SETTLE_LOAD = SETTLE_BITS'(SCALE_LATENCY - 1);

   localparam logic [FREQ_BITS-1:0] MAX_FREQ_RESET = '1;
   localparam logic [FREQ_BITS-1:0] MIN_FREQ_RESET = '0;
   localparam logic [PCT_BITS-1:0] UP_THRESHOLD_RESET = 7'd80;
   localparam logic [PCT_BITS-1:0] DOWN_THRESHOLD_RESET = 7'd30;
   localparam logic [PCT_BITS-1:0] STEP_PCT_RESET = 7'd8;
   localparam logic [PCT_BITS-1:0] HISPEED_PCT_RESET = 7'd70;

   typedef enum logic [2:0] {
      REG_MAX_FREQ       = 3'd0,
      REG_MIN_FREQ       = 3'd1,
      REG_UP_THRESHOLD   = 3'd2,
      REG_DOWN_THRESHOLD = 3'd3,
      REG_STEP_PCT       = 3'd4,
      REG_HISPEED_PCT    = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [PCT_BITS-1:0]  load_pct;
      logic [FREQ_BITS-1:0] cur_freq;
   } req_beat_type;

   typedef struct packed {
      logic                 request_valid;
      logic [FREQ_BITS-1:0] target_freq;
      logic                 relation_high;
      logic                 floor_armed;
   } rsp_beat_type;

   typedef struct packed {
      logic [FREQ_BITS:0]   step;
      logic [FREQ_BITS-1:0] hispeed_freq;
   } scale_type;

endpackage

// File: hdl/sfg_scale.sv
// ----------------------------------------------------------------------------
// Step and floor scaling
// Pipeline that derives the step size and the floor frequency from the
// maximum frequency and the two percentages, splitting the maximum into a
// quotient and remainder by one hundred so that no wide divider is needed.
// ----------------------------------------------------------------------------
module sfg_scale (
   input  logic                             clock,
   input  logic [sfg_pkg::FREQ_BITS-1:0]    max_freq,
   input  logic [sfg_pkg::PCT_BITS-1:0]     step_pct,
   input  logic [sfg_pkg::PCT_BITS-1:0]     hispeed_pct,
   output sfg_pkg::scale_type               scale
);
   import sfg_pkg::*;

   localparam int LO_BITS = FREQ_BITS / 2;
   localparam int HI_BITS = FREQ_BITS - LO_BITS;
   localparam int PH_BITS = HI_BITS + RECIP_BITS;
   localparam int PL_BITS = LO_BITS + RECIP_BITS;
   localparam int FULL_BITS = FREQ_BITS + RECIP_BITS;
   localparam int PA_BITS = QUOT_BITS + PCT_BITS;
   localparam int PQ_BITS = 2 * SMALL_BITS;

   logic [PH_BITS-1:0]    pp_hi_ff, pp_hi_in;
   logic [PL_BITS-1:0]    pp_lo_ff, pp_lo_in;
   logic [FULL_BITS-1:0]  full_sum;
   logic [QUOT_BITS-1:0]  q_est_ff, q_est_in;
   logic [FREQ_BITS-1:0]  rem_full;
   logic [REM_BITS-1:0]   rem_low;
   logic [QUOT_BITS-1:0]  quot_ff, quot_in;
   logic [PCT_BITS-1:0]   rem_ff, rem_in;
   logic [PA_BITS-1:0]    step_a_ff, step_a_in, floor_a_ff, floor_a_in;
   logic [SMALL_BITS-1:0] step_b_ff, step_b_in, floor_b_ff, floor_b_in;
   logic [QUOT_BITS-1:0]  quot_d_ff;
   logic [PQ_BITS-1:0]    step_q_prod, floor_q_prod;
   logic [FREQ_BITS:0]    step_raw, floor_raw;
   scale_type             scale_ff, scale_in;

   always_comb begin
      pp_hi_in = PH_BITS'(max_freq[FREQ_BITS-1:LO_BITS]) * PH_BITS'(FREQ_RECIP);
      pp_lo_in = PL_BITS'(max_freq[LO_BITS-1:0]) * PL_BITS'(FREQ_RECIP);

      full_sum = (FULL_BITS'(pp_hi_ff) << LO_BITS) + FULL_BITS'(pp_lo_ff);
      q_est_in = full_sum[RECIP_SHIFT +: QUOT_BITS];

      rem_full = max_freq - FREQ_BITS'(q_est_ff) * FREQ_BITS'(HUNDRED);
      rem_low = rem_full[REM_BITS-1:0];
      if (rem_low >= HUNDRED) begin
         quot_in = q_est_ff + QUOT_BITS'(1);
         rem_in = PCT_BITS'(rem_low - HUNDRED);
      end else begin
         quot_in = q_est_ff;
         rem_in = rem_low[PCT_BITS-1:0];
      end

      step_a_in = PA_BITS'(step_pct) * PA_BITS'(quot_ff);
      floor_a_in = PA_BITS'(hispeed_pct) * PA_BITS'(quot_ff);
      step_b_in = SMALL_BITS'(step_pct) * SMALL_BITS'(rem_ff);
      floor_b_in = SMALL_BITS'(hispeed_pct) * SMALL_BITS'(rem_ff);

      step_q_prod = PQ_BITS'(step_b_ff) * PQ_BITS'(PCT_RECIP);
      floor_q_prod = PQ_BITS'(floor_b_ff) * PQ_BITS'(PCT_RECIP);
      step_raw = (FREQ_BITS + 1)'(step_a_ff)
               + (FREQ_BITS + 1)'(step_q_prod[PCT_RECIP_SHIFT +: PCT_BITS]);
      floor_raw = (FREQ_BITS + 1)'(floor_a_ff)
                + (FREQ_BITS + 1)'(floor_q_prod[PCT_RECIP_SHIFT +: PCT_BITS]);

      if (step_raw == '0) begin
         scale_in.step = (FREQ_BITS + 1)'(quot_d_ff);
      end else begin
         scale_in.step = step_raw;
      end
      if (floor_raw > (FREQ_BITS + 1)'(max_freq)) begin
         scale_in.hispeed_freq = max_freq;
      end else begin
         scale_in.hispeed_freq = floor_raw[FREQ_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      pp_hi_ff <= pp_hi_in;
      pp_lo_ff <= pp_lo_in;
      q_est_ff <= q_est_in;
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      step_a_ff <= step_a_in;
      floor_a_ff <= floor_a_in;
      step_b_ff <= step_b_in;
      floor_b_ff <= floor_b_in;
      quot_d_ff <= quot_ff;
      scale_ff <= scale_in;
   end

   assign scale = scale_ff;

endmodule

// File: hdl/stepped_freq_governor_with_floor_unit.sv
// ----------------------------------------------------------------------------
// Stepped frequency governor with hispeed floor
// Takes one beat per clock while req_stall is low and returns one result beat
// per input beat; a beat waits in the input register until the result register
// is free. The decision is a single pass of compares, an add and a subtract
// between the input and result registers, so back-to-back beats run at one per
// cycle while rsp_stall is low. Step size and floor frequency come from a
// five-stage scaling pipeline fed by the registers, so req_stall is held high
// after reset and after every register write while that pipeline refreshes.
// ----------------------------------------------------------------------------
`include "stepped_freq_governor_with_floor_unit_macros.svh"

module stepped_freq_governor_with_floor_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  sfg_pkg::req_beat_type           req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output sfg_pkg::rsp_beat_type           rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [sfg_pkg::ADDR_BITS-1:0]   paddr,
   input  logic [sfg_pkg::DATA_BITS-1:0]   pwdata,
   output logic [sfg_pkg::DATA_BITS-1:0]   prdata,
   output logic                            pready
);
   import sfg_pkg::*;

   logic [FREQ_BITS-1:0]   max_freq_ff, min_freq_ff;
   logic [PCT_BITS-1:0]    up_threshold_ff, down_threshold_ff, step_pct_ff, hispeed_pct_ff;
   logic [SETTLE_BITS-1:0] settle_ff, settle_in;
   reg_index_type          reg_index;
   logic                   cfg_write;
   scale_type              scale;

   logic                   in_valid_ff, in_valid_in;
   req_beat_type           in_ff;
   logic                   out_valid_ff, out_valid_in;
   rsp_beat_type           out_ff, out_in;
   logic [FREQ_BITS-1:0]   last_request_ff;
   logic                   request_known_ff, floor_on_ff;
   logic                   req_accept, advance;

   logic [FREQ_BITS-1:0]   base;
   logic [FREQ_BITS+1:0]   up_sum;
   logic [FREQ_BITS-1:0]   target;
   logic                   step_up, load_low, floor_next;

   assign pready = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign reg_index = reg_index_type'(paddr[ADDR_BITS-1:2]);

   always_comb begin
      case (reg_index)
         REG_MAX_FREQ:       prdata = DATA_BITS'(max_freq_ff);
         REG_MIN_FREQ:       prdata = DATA_BITS'(min_freq_ff);
         REG_UP_THRESHOLD:   prdata = DATA_BITS'(up_threshold_ff);
         REG_DOWN_THRESHOLD: prdata = DATA_BITS'(down_threshold_ff);
         REG_STEP_PCT:       prdata = DATA_BITS'(step_pct_ff);
         REG_HISPEED_PCT:    prdata = DATA_BITS'(hispeed_pct_ff);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_freq_ff <= MAX_FREQ_RESET;
         min_freq_ff <= MIN_FREQ_RESET;
         up_threshold_ff <= UP_THRESHOLD_RESET;
         down_threshold_ff <= DOWN_THRESHOLD_RESET;
         step_pct_ff <= STEP_PCT_RESET;
         hispeed_pct_ff <= HISPEED_PCT_RESET;
      end else if (cfg_write) begin
         case (reg_index)
            REG_MAX_FREQ:       max_freq_ff <= pwdata[FREQ_BITS-1:0];
            REG_MIN_FREQ:       min_freq_ff <= pwdata[FREQ_BITS-1:0];
            REG_UP_THRESHOLD:   up_threshold_ff <= pwdata[PCT_BITS-1:0];
            REG_DOWN_THRESHOLD: down_threshold_ff <= pwdata[PCT_BITS-1:0];
            REG_STEP_PCT:       step_pct_ff <= pwdata[PCT_BITS-1:0];
            REG_HISPEED_PCT:    hispeed_pct_ff <= pwdata[PCT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   sfg_scale u_scale (
      .clock       (clock),
      .max_freq    (max_freq_ff),
      .step_pct    (step_pct_ff),
      .hispeed_pct (hispeed_pct_ff),
      .scale       (scale)
   );

   always_comb begin
      if (cfg_write) begin
         settle_in = SETTLE_LOAD;
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - SETTLE_BITS'(1);
      end else begin
         settle_in = settle_ff;
      end
   end

   assign advance = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = (settle_ff != '0) || (in_valid_ff && !advance);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_comb begin
      if (!request_known_ff || last_request_ff > max_freq_ff
          || last_request_ff < min_freq_ff) begin
         base = in_ff.cur_freq;
      end else begin
         base = last_request_ff;
      end
      step_up = in_ff.load_pct > up_threshold_ff;
      load_low = in_ff.load_pct < down_threshold_ff;
      up_sum = (FREQ_BITS + 2)'(base) + (FREQ_BITS + 2)'(scale.step);
      floor_next = floor_on_ff;
      target = base;
      out_in.request_valid = 1'b0;
      out_in.relation_high = 1'b0;
      if (step_up) begin
         floor_next = 1'b1;
         if (up_sum > (FREQ_BITS + 2)'(max_freq_ff)) begin
            target = max_freq_ff;
         end else begin
            target = up_sum[FREQ_BITS-1:0];
         end
         out_in.request_valid = 1'b1;
         out_in.relation_high = 1'b1;
      end else begin
         if (load_low) begin
            floor_next = 1'b0;
         end
         if (floor_next) begin
            if (base < scale.hispeed_freq) begin
               target = scale.hispeed_freq;
            end
         end else if (load_low) begin
            if ((FREQ_BITS + 1)'(base) > scale.step) begin
               target = base - scale.step[FREQ_BITS-1:0];
            end else begin
               target = '0;
            end
         end
         if (target < min_freq_ff) begin
            target = min_freq_ff;
         end
         out_in.request_valid = target != in_ff.cur_freq;
      end
      out_in.target_freq = target;
      out_in.floor_armed = floor_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= SETTLE_LOAD;
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         last_request_ff <= '0;
         request_known_ff <= 1'b0;
         floor_on_ff <= 1'b0;
      end else begin
         settle_ff <= settle_in;
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            last_request_ff <= target;
            request_known_ff <= 1'b1;
            floor_on_ff <= floor_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_ff <= req_data;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;

   `SFG_ASSERT_NEXT(a_no_accept_after_write, cfg_write, !req_accept)
   `SFG_ASSERT_NEXT(a_advance_shows_result, advance, rsp_valid)
   `SFG_ASSERT_NEXT(a_held_while_blocked, in_valid_ff && out_valid_ff && rsp_stall, in_valid_ff)
   `SFG_ASSERT_SAME(a_step_up_issues, rsp_valid && rsp_data.relation_high, rsp_data.request_valid && rsp_data.floor_armed)

endmodule
